// ===== hw/rtl/nps_pkg.sv =====
`default_nettype none
package nps_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DECOMP,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_POW_SHIFT,
    ST_CHECK,
    ST_SQ_LOOP,
    ST_SQ_CHECK,
    ST_VERDICT,
    ST_NEXT_CAND,
    ST_DONE
  } state_t;

  // Request to and reply from the shared modular multiplier.
  typedef struct packed {
    logic        start;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] m;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] prod;
  } mul_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/next_prime_search.sv =====
`default_nettype none
// Channel  | Direction | Payload
// in_      | slave     | tdata[15:0] = value
// out_     | master    | tdata[15:0] = next_prime; tuser[1:0] = {found, is_prime}
//
// One shared modular multiplier computes every modular product. A product runs
// from its start request through one load, 32 remainder steps and one done
// register to the cycle that sees done. An item runs Miller-Rabin on the value
// and then on each odd candidate, so its run time is set by candidate count and
// exponent length.
// in_tready is high only when idle and no result is held. The result is held
// in out_ registers until taken. Reset clears the sequencer and the output valid flag.
module next_prime_search
  import nps_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // next_prime
  output logic [1:0]       out_tuser   // found, is_prime
);

  localparam logic [16:0] VMAX = 17'((1 << VALUE_BITS) - 1);
  localparam logic [16:0] HMAX = VMAX >> 1;

  state_t state_r, state_nxt;
  state_t state_prev_r;
  logic [15:0] v_r, v_nxt;
  logic [15:0] n_r, n_nxt;       // number under test
  logic [16:0] lim_r, lim_nxt;
  logic        phase_r, phase_nxt; // 0: testing v, 1: searching
  logic [15:0] d_r, d_nxt;
  logic [4:0]  s_r, s_nxt;
  logic [4:0]  i_r, i_nxt;
  logic        base_r, base_nxt;  // 0: base 2, 1: base 3
  logic [15:0] x_r, x_nxt;
  logic [15:0] b_r, b_nxt;
  logic [15:0] e_r, e_nxt;
  logic        pass_r, pass_nxt;
  logic        isp_r, isp_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [15:0] onext_r, onext_nxt;
  logic        ofound_r, ofound_nxt;
  logic        oisp_r, oisp_nxt;
  mul_req_t    req;
  mul_rsp_t    rsp;
  logic [15:0] vm;
  logic [16:0] start;

  nps_modmul u_mul (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign vm    = in_tdata & VMAX[15:0];
  assign start = v_r[0] ? {1'b0, v_r} + 17'd2 : {1'b0, v_r} + 17'd1;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_tvalid && in_tready) state_nxt = ST_SETUP;
      ST_SETUP:     begin
        if (n_r <= 16'd3 || !n_r[0]) state_nxt = ST_VERDICT;
        else state_nxt = ST_DECOMP;
      end
      ST_DECOMP:    if (d_r[0]) state_nxt = ST_POW_MUL;
      ST_POW_MUL:   begin
        if (e_r == 16'd0) state_nxt = ST_CHECK;
        else if (!e_r[0]) state_nxt = ST_POW_SQR;
        else if (rsp.done) state_nxt = ST_POW_SQR;
      end
      ST_POW_SQR:   if (rsp.done) state_nxt = ST_POW_SHIFT;
      ST_POW_SHIFT: state_nxt = ST_POW_MUL;
      ST_CHECK:     begin
        if (x_r == 16'd1 || x_r == n_r - 16'd1 || s_r <= 5'd1) state_nxt = ST_VERDICT;
        else state_nxt = ST_SQ_LOOP;
      end
      ST_SQ_LOOP:   if (rsp.done) state_nxt = ST_SQ_CHECK;
      ST_SQ_CHECK:  begin
        if (rsp.prod == n_r - 16'd1 || rsp.prod == 16'd1 || i_r + 5'd1 >= s_r)
          state_nxt = ST_VERDICT;
        else state_nxt = ST_SQ_LOOP;
      end
      ST_VERDICT:   begin
        if (base_nxt && !base_r && pass_nxt) state_nxt = ST_POW_MUL;
        else state_nxt = ST_NEXT_CAND;
      end
      ST_NEXT_CAND: state_nxt = (phase_nxt && !ofound_nxt && ({1'b0, n_nxt} < lim_nxt))
                                ? ST_SETUP : ST_DONE;
      ST_DONE:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    v_nxt = v_r; n_nxt = n_r; lim_nxt = lim_r; phase_nxt = phase_r;
    d_nxt = d_r; s_nxt = s_r; i_nxt = i_r; base_nxt = base_r;
    x_nxt = x_r; b_nxt = b_r; e_nxt = e_r; pass_nxt = pass_r; isp_nxt = isp_r;
    ovalid_nxt = ovalid_r; onext_nxt = onext_r; ofound_nxt = ofound_r; oisp_nxt = oisp_r;
    req = '0;
    req.m = n_r;
    if (out_tvalid && out_tready) ovalid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          v_nxt = vm; n_nxt = vm; phase_nxt = 1'b0;
          onext_nxt = 16'd0; ofound_nxt = 1'b0;
        end
      end
      ST_SETUP: begin
        d_nxt = n_r - 16'd1; s_nxt = 5'd0; base_nxt = 1'b0;
        pass_nxt = (n_r >= 16'd2) && (n_r <= 16'd3);
        x_nxt = 16'd1; b_nxt = 16'd2; e_nxt = n_r - 16'd1;
      end
      ST_DECOMP: begin
        if (!d_r[0]) begin
          d_nxt = d_r >> 1; s_nxt = s_r + 5'd1;
        end else begin
          e_nxt = d_r;
        end
      end
      ST_POW_MUL: begin
        req.a = x_r; req.b = b_r;
        if (rsp.done) x_nxt = rsp.prod;
      end
      ST_POW_SQR: begin
        req.a = b_r; req.b = b_r;
        if (rsp.done) b_nxt = rsp.prod;
      end
      ST_POW_SHIFT: e_nxt = e_r >> 1;
      ST_CHECK: begin
        i_nxt = 5'd1;
        pass_nxt = (x_r == 16'd1) || (x_r == n_r - 16'd1);
      end
      ST_SQ_LOOP: begin
        req.a = x_r; req.b = x_r;
      end
      ST_SQ_CHECK: begin
        x_nxt = rsp.prod; i_nxt = i_r + 5'd1;
        pass_nxt = (rsp.prod == n_r - 16'd1);
      end
      ST_VERDICT: begin
        if (!base_r && pass_r && n_r > 16'd3) begin
          base_nxt = 1'b1; x_nxt = 16'd1; b_nxt = 16'd3; e_nxt = d_r;
        end
        pass_nxt = pass_r;
      end
      ST_NEXT_CAND: begin
        if (!phase_r) begin
          isp_nxt = pass_r; phase_nxt = 1'b1;
          if (v_r <= 16'd1) begin
            onext_nxt = 16'd2; ofound_nxt = 1'b1;
          end else if (v_r == 16'd2) begin
            onext_nxt = 16'd3; ofound_nxt = 1'b1;
          end else if (start <= VMAX) begin
            n_nxt = start[15:0];
            lim_nxt = (start > HMAX) ? VMAX : {start[15:0], 1'b0};
          end else begin
            lim_nxt = 17'd0;
          end
        end else if (pass_r) begin
          onext_nxt = n_r; ofound_nxt = 1'b1;
        end else begin
          n_nxt = n_r + 16'd2;
          if ({1'b0, n_r} + 17'd2 > VMAX) lim_nxt = 17'd0;
        end
      end
      ST_DONE: begin
        ovalid_nxt = 1'b1; oisp_nxt = isp_r;
      end
      default: ;
    endcase
    // The multiplier starts on entry to a product state; POW_MUL only if e_r[0].
    if ((state_r == ST_POW_SQR || state_r == ST_SQ_LOOP) && state_r != state_prev_r)
      req.start = 1'b1;
    if (state_r == ST_POW_MUL) req.start = (state_r != state_prev_r) && e_r != 16'd0 && e_r[0];
    if (state_r == ST_POW_MUL || state_r == ST_POW_SQR) req.m = n_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      state_prev_r <= ST_DONE;
      ovalid_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      state_prev_r <= (state_r == ST_POW_SHIFT || state_r == ST_SQ_CHECK) ? ST_IDLE : state_r;
      ovalid_r     <= ovalid_nxt;
    end
    v_r <= v_nxt; n_r <= n_nxt; lim_r <= lim_nxt; phase_r <= phase_nxt;
    d_r <= d_nxt; s_r <= s_nxt; i_r <= i_nxt; base_r <= base_nxt;
    x_r <= x_nxt; b_r <= b_nxt; e_r <= e_nxt; pass_r <= pass_nxt; isp_r <= isp_nxt;
    onext_r <= onext_nxt; ofound_r <= ofound_nxt; oisp_r <= oisp_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = onext_r;
  assign out_tuser  = {ofound_r, oisp_r};

endmodule
`default_nettype wire

// ===== hw/rtl/nps_modmul.sv =====
`default_nettype none
// Computes (a * b) mod m, one restoring remainder bit per cycle.
module nps_modmul
  import nps_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  logic        busy_r, busy_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] m_r, m_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [16:0] shifted;

  assign shifted = {rem_r[15:0], prod_r[31]};

  always_comb begin
    busy_nxt = busy_r;
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    m_nxt    = m_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      prod_nxt = req.a * req.b;
      rem_nxt  = 17'd0;
      m_nxt    = req.m;
      cnt_nxt  = 6'd0;
    end else if (busy_r) begin
      prod_nxt = {prod_r[30:0], 1'b0};
      if (shifted >= {1'b0, m_r}) begin
        rem_nxt = shifted - {1'b0, m_r};
      end else begin
        rem_nxt = shifted;
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    m_r    <= m_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = rem_r[15:0];

endmodule
`default_nettype wire
